// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/wdsc_pkg.sv -----
package wdsc_pkg;

    localparam int ID_W        = 31;
    localparam int KEY_W       = 10;
    localparam int SUM_W       = 9;
    localparam int MAX_DIGITS  = 10;
    localparam int POS_W       = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W     = 4;
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = ID_W + RECIP_W;
    localparam int DIV10_SHIFT = 35;
    localparam int REM_BITS    = 3;
    localparam int REM_STAGES  = SUM_W / REM_BITS;
    localparam int IN_TDATA_W  = ((ID_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

    localparam logic [RECIP_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam logic [KEY_W-1:0]   KEY_RESET   = 10'd11;
    localparam logic [SUM_W-1:0]   SUM_MAX     = 9'd495;
    localparam logic [SUM_W-1:0]   ONES_MAX    = 9'd9;

    typedef struct packed {
        logic [ID_W-1:0]  rest;
        logic [SUM_W-1:0] acc;
    } t_dig;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] pend;
        logic [KEY_W-1:0] rem;
    } t_rem;

endpackage

// ----- rtl/wdsc_digit_stage.sv -----
module wdsc_digit_stage
    import wdsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_dig             i_data,
    input  logic [POS_W-1:0] i_weight,
    output logic             o_valid,
    input  logic             i_ready,
    output t_dig             o_data
);

    logic                 r_valid;
    t_dig                 r_data;
    t_dig                 n_data;
    logic [PROD_W-1:0]    prod;
    logic [ID_W-1:0]      quot;
    logic [ID_W-1:0]      quot10;
    logic [DIGIT_W-1:0]   digit;
    logic [POS_W+DIGIT_W-1:0] term;

    // rest / 10 by reciprocal multiply, exact for any 31-bit dividend
    always_comb begin
        prod   = PROD_W'(i_data.rest) * PROD_W'(DIV10_RECIP);
        quot   = ID_W'(prod >> DIV10_SHIFT);
        quot10 = (quot << 3) + (quot << 1);
        digit  = DIGIT_W'(i_data.rest - quot10);
        term   = (POS_W+DIGIT_W)'(i_weight) * (POS_W+DIGIT_W)'(digit);
        n_data.rest = quot;
        n_data.acc  = i_data.acc + SUM_W'(term);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/wdsc_rem_stage.sv -----
module wdsc_rem_stage
    import wdsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_rem             i_data,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_valid,
    input  logic             i_ready,
    output t_rem             o_data
);

    logic             r_valid;
    t_rem             r_data;
    t_rem             n_data;
    logic [KEY_W:0]   trial;
    logic [SUM_W-1:0] pend;
    logic [KEY_W-1:0] rem;

    // restoring remainder, REM_BITS (3) sum bits per stage, MSB first
    always_comb begin
        pend  = i_data.pend;
        rem   = i_data.rem;
        trial = '0;
        for (int b = 0; b < REM_BITS; b++) begin
            trial = {rem, pend[SUM_W-1]};
            pend  = pend << 1;
            if (trial >= {1'b0, i_key}) begin
                trial = trial - {1'b0, i_key};
            end
            rem = trial[KEY_W-1:0];
        end
        n_data.sum  = i_data.sum;
        n_data.pend = pend;
        n_data.rem  = rem;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/weighted_digit_sum_check.sv -----
// Pipeline: 10 digit stages, one decimal digit each, then 3 remainder stages
// of 3 sum bits each. Throughput: one identifier per cycle unless the output
// stalls; every stage holds its own valid bit and advances whenever the stage
// after it is empty or taking its data.
// Reset (synchronous, active low) empties the pipeline and sets the key to 11.
module weighted_digit_sum_check
    import wdsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [KEY_W-1:0]       i_cfg_data,      // check_key
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // ident[30:0], zero[31]
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // digit_sum[8:0], zero[15:9]
    output logic                   o_m_axis_tuser   // key_ok
);

`include "assert_macros.svh"

    logic [KEY_W-1:0] r_key;

    logic dig_v   [MAX_DIGITS];
    logic dig_rdy [MAX_DIGITS];
    t_dig dig_d   [MAX_DIGITS];
    logic rem_v   [REM_STAGES];
    logic rem_rdy [REM_STAGES];
    t_rem rem_d   [REM_STAGES];

    t_dig dig_in;
    t_rem rem_in;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
        end else if (i_cfg_valid) begin
            r_key <= i_cfg_data;
        end
    end

    assign dig_in.rest = i_s_axis_tdata[ID_W-1:0];
    assign dig_in.acc  = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_DIGITS; k++) begin : g_dig
            if (k == 0) begin : g_first
                wdsc_digit_stage u_stage (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_valid  (i_s_axis_tvalid),
                    .o_ready  (o_s_axis_tready),
                    .i_data   (dig_in),
                    .i_weight (POS_W'(k + 1)),
                    .o_valid  (dig_v[k]),
                    .i_ready  (dig_rdy[k]),
                    .o_data   (dig_d[k])
                );
            end else begin : g_next
                wdsc_digit_stage u_stage (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_valid  (dig_v[k-1]),
                    .o_ready  (dig_rdy[k-1]),
                    .i_data   (dig_d[k-1]),
                    .i_weight (POS_W'(k + 1)),
                    .o_valid  (dig_v[k]),
                    .i_ready  (dig_rdy[k]),
                    .o_data   (dig_d[k])
                );
            end
        end
    endgenerate

    assign rem_in.sum  = dig_d[MAX_DIGITS-1].acc;
    assign rem_in.pend = dig_d[MAX_DIGITS-1].acc;
    assign rem_in.rem  = '0;

    generate
        for (k = 0; k < REM_STAGES; k++) begin : g_rem
            if (k == 0) begin : g_first
                wdsc_rem_stage u_stage (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (dig_v[MAX_DIGITS-1]),
                    .o_ready (dig_rdy[MAX_DIGITS-1]),
                    .i_data  (rem_in),
                    .i_key   (r_key),
                    .o_valid (rem_v[k]),
                    .i_ready (rem_rdy[k]),
                    .o_data  (rem_d[k])
                );
            end else begin : g_next
                wdsc_rem_stage u_stage (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (rem_v[k-1]),
                    .o_ready (rem_rdy[k-1]),
                    .i_data  (rem_d[k-1]),
                    .i_key   (r_key),
                    .o_valid (rem_v[k]),
                    .i_ready (rem_rdy[k]),
                    .o_data  (rem_d[k])
                );
            end
        end
    endgenerate

    assign rem_rdy[REM_STAGES-1] = i_m_axis_tready;
    assign o_m_axis_tvalid = rem_v[REM_STAGES-1];
    assign o_m_axis_tdata  = OUT_TDATA_W'(rem_d[REM_STAGES-1].sum);
    assign o_m_axis_tuser  = (rem_d[REM_STAGES-1].rem == '0);

    `ASSERT_NEXT(a_enter_first, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, dig_v[0])
    `ASSERT_NOW(a_ones_digit, i_clk, i_rst_n, dig_v[0], dig_d[0].acc <= ONES_MAX)
    `ASSERT_NOW(a_rem_below_key, i_clk, i_rst_n, rem_v[0] && (r_key != '0), rem_d[0].rem < r_key)
    `ASSERT_NOW(a_sum_range, i_clk, i_rst_n, o_m_axis_tvalid, rem_d[REM_STAGES-1].sum <= SUM_MAX)

endmodule

// ----- bench/weighted_digit_sum_check_test.sv -----
`timescale 1ns / 1ps

module weighted_digit_sum_check_test;
    import wdsc_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_HOLD  = 16;
    localparam int RANDOM_PER_PHASE = 250;

    class digit_sum_scoreboard;
        typedef struct packed {
            logic             key_ok;
            logic [SUM_W-1:0] digit_sum;
        } t_verdict;

        logic [KEY_W-1:0] key;
        t_verdict         pending[$];
        int               errors;

        function new();
            key    = KEY_RESET;
            errors = 0;
        endfunction

        function void set_key(logic [KEY_W-1:0] k);
            key = k;
        endfunction

        function logic [SUM_W-1:0] weigh_digits(logic [ID_W-1:0] id);
            int unsigned acc;
            int unsigned rest;
            acc  = 0;
            rest = id;
            for (int unsigned pos = 1; pos <= MAX_DIGITS; pos++) begin
                acc += pos * (rest % 10);
                rest /= 10;
            end
            if (acc > 511) begin
                acc = 511;
            end
            return acc[SUM_W-1:0];
        endfunction

        function void note_id(logic [ID_W-1:0] id);
            t_verdict v;
            int unsigned sum;
            v.digit_sum = weigh_digits(id);
            sum = v.digit_sum;
            if (key == '0) begin
                v.key_ok = (sum == 0);
            end else begin
                v.key_ok = ((sum % key) == 0);
            end
            pending.push_back(v);
        endfunction

        function void check_verdict(logic key_ok, logic [SUM_W-1:0] digit_sum);
            t_verdict v;
            if (pending.size() == 0) begin
                $error("unexpected result: digit_sum %0d key_ok %0d", digit_sum, key_ok);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (digit_sum !== v.digit_sum) begin
                $error("digit_sum: expected %0d, actual %0d", v.digit_sum, digit_sum);
                errors++;
            end
            if (key_ok !== v.key_ok) begin
                $error("key_ok: expected %0d, actual %0d", v.key_ok, key_ok);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [KEY_W-1:0]       i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;

    digit_sum_scoreboard verdicts = new();
    bit sender_burst;
    bit sink_burst;

    weighted_digit_sum_check dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // All driving tasks start and end right after a falling edge.
    task automatic send_id(logic [ID_W-1:0] id);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W-ID_W){1'b0}}, id};
        do @(posedge i_clk); while (!o_s_axis_tready);
        verdicts.note_id(id);
        @(negedge i_clk);
    endtask

    // Drop valid, then hold until every result is back and the pipeline is empty.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (verdicts.outstanding() > 0) @(posedge i_clk);
        repeat (DRAIN_HOLD) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_key(logic [KEY_W-1:0] k);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        verdicts.set_key(k);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [ID_W-1:0] draw_id();
        longint v;
        longint p;
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom() & 32'h7FFF_FFFF;
            4, 5:       v = $urandom_range(0, 999);
            6, 7: begin
                n = $urandom_range(1, 10);
                v = 0;
                for (int i = 0; i < n; i++) begin
                    v = v * 10 + $urandom_range(0, 9);
                end
                if (v > 64'd2147483647) begin
                    v = v % 64'd2147483648;
                end
            end
            8: begin
                p = 1;
                n = $urandom_range(0, 9);
                for (int i = 0; i < n; i++) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
                if (v < 0) v = 0;
            end
            default: begin
                p = 1;
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++) p = p * 10;
                v = ($urandom_range(0, 1) == 1) ? p - 1 : 64'd2147483647 - $urandom_range(0, 50);
            end
        endcase
        return v[ID_W-1:0];
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                sender_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) == 0) begin
                wait_drained();
            end
            send_id(draw_id());
        end
        wait_drained();
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        @(negedge i_clk iff i_rst_n);
        forever begin
            if (taken % 64 == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            stall = sink_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            verdicts.check_verdict(o_m_axis_tuser, o_m_axis_tdata[SUM_W-1:0]);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [ID_W-1:0] directed_ids[$];
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        sender_burst    = 1'b0;
        sink_burst      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset key, digit extremes and decade boundaries.
        directed_ids = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd19, 31'd91, 31'd99,
                         31'd100, 31'd999999999, 31'd1000000000, 31'd1999999999,
                         31'd2000000000, 31'd2147483646, 31'd2147483647, 31'd1073741824,
                         31'd1234567890, 31'd987654321, 31'd1111111111};
        foreach (directed_ids[i]) send_id(directed_ids[i]);
        wait_drained();

        // Key of zero: only a zero sum passes.
        write_key('0);
        send_id(31'd0);
        send_id(31'd5);
        send_id(31'd1000000000);
        wait_drained();
        write_key('1);
        send_id(31'd2147483647);
        send_id(31'd0);
        wait_drained();
        write_key(10'd1);
        send_id(31'd1999999999);
        wait_drained();

        write_key(KEY_RESET);
        random_phase(RANDOM_PER_PHASE);
        write_key('0);
        random_phase(RANDOM_PER_PHASE);
        write_key(10'd1);
        random_phase(RANDOM_PER_PHASE);
        write_key('1);
        random_phase(RANDOM_PER_PHASE);
        write_key(KEY_W'($urandom_range(2, 30)));
        random_phase(RANDOM_PER_PHASE);
        write_key(KEY_W'($urandom_range(1, 1023)));
        random_phase(RANDOM_PER_PHASE);

        sender_burst = 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (verdicts.outstanding() > 0) begin
            $error("%0d results never arrived", verdicts.outstanding());
            verdicts.errors++;
        end
        if (verdicts.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- weighted_digit_sum_check.f -----
+incdir+rtl
rtl/wdsc_pkg.sv
rtl/wdsc_digit_stage.sv
rtl/wdsc_rem_stage.sv
rtl/weighted_digit_sum_check.sv
bench/weighted_digit_sum_check_test.sv
